>>> src/gpio_prb_pkg.sv
// Shared types and constants for the GPIO pin register block.
// Holds the request/response structs, register word offsets and field codes.
// No dependencies.
package gpio_prb_pkg;

    localparam int PAD_COUNT      = 54;  // width of the pad and pin vectors
    localparam int FSEL_WORDS     = 6;
    localparam int FSEL_PER_WORD  = 10;
    localparam int FSEL_PIN_LIMIT = FSEL_WORDS * FSEL_PER_WORD;
    localparam int PINS_MAX       = 64;

    // access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // register word offsets
    localparam logic [5:0] W_FSEL0     = 6'd0;
    localparam logic [5:0] W_FSEL_LAST = 6'd5;
    localparam logic [5:0] W_SET0      = 6'd7;
    localparam logic [5:0] W_SET1      = 6'd8;
    localparam logic [5:0] W_CLR0      = 6'd10;
    localparam logic [5:0] W_CLR1      = 6'd11;
    localparam logic [5:0] W_LEV0      = 6'd13;
    localparam logic [5:0] W_LEV1      = 6'd14;
    localparam logic [5:0] W_PUD       = 6'd37;
    localparam logic [5:0] W_PUDCLK0   = 6'd38;
    localparam logic [5:0] W_PUDCLK1   = 6'd39;

    // field codes
    localparam logic [2:0] FSEL_OUTPUT = 3'd1;
    localparam logic [1:0] PULL_DOWN   = 2'd1;
    localparam logic [1:0] PULL_UP     = 2'd2;

    typedef struct packed {
        logic                 opcode;
        logic [5:0]           reg_index;
        logic [31:0]          write_data;
        logic [PAD_COUNT-1:0] pad_levels;
    } gpio_req_t;

    typedef struct packed {
        logic [31:0]          read_data;
        logic [PAD_COUNT-1:0] pin_drive;
        logic [PAD_COUNT-1:0] pin_output_enable;
        logic [PAD_COUNT-1:0] pull_up_mask;
        logic [PAD_COUNT-1:0] pull_down_mask;
    } gpio_rsp_t;

endpackage

>>> src/gpio_prb_regfile.sv
// Register state of the GPIO block: function selects, output latch, pull control.
// Applies one access when enabled and forms the response from the updated state.
// Depends on gpio_prb_pkg.
module gpio_prb_regfile
    import gpio_prb_pkg::*;
#(
    parameter int PIN_COUNT = 54
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  gpio_req_t req,
    output gpio_rsp_t rsp
);

    localparam int FSEL_PINS = (PIN_COUNT < FSEL_PIN_LIMIT) ? PIN_COUNT : FSEL_PIN_LIMIT;

    logic [2:0]           fsel_reg  [FSEL_PINS];
    logic [2:0]           fsel_next [FSEL_PINS];
    logic [PIN_COUNT-1:0] latch_reg;
    logic [PIN_COUNT-1:0] latch_next;
    logic [1:0]           pud_reg;
    logic [1:0]           pud_next;
    logic [1:0]           pull_reg  [PIN_COUNT];
    logic [1:0]           pull_next [PIN_COUNT];

    logic                 wr;
    logic [63:0]          lo_word;
    logic [63:0]          hi_word;
    logic [PIN_COUNT-1:0] lo_mask;
    logic [PIN_COUNT-1:0] hi_mask;

    assign wr      = en && (req.opcode == OP_WRITE);
    assign lo_word = {32'b0, req.write_data};
    assign hi_word = {req.write_data, 32'b0};
    assign lo_mask = lo_word[PIN_COUNT-1:0];
    assign hi_mask = hi_word[PIN_COUNT-1:0];

    // next state
    always_comb
    begin
        int p;
        p          = 0;
        latch_next = latch_reg;
        pud_next   = pud_reg;
        for (int i = 0; i < FSEL_PINS; i++)
        begin
            fsel_next[i] = fsel_reg[i];
        end
        for (int i = 0; i < PIN_COUNT; i++)
        begin
            pull_next[i] = pull_reg[i];
        end

        if (wr)
        begin
            unique case (req.reg_index) inside
                [W_FSEL0:W_FSEL_LAST]:
                begin
                    for (int w = 0; w < FSEL_WORDS; w++)
                    begin
                        for (int k = 0; k < FSEL_PER_WORD; k++)
                        begin
                            p = w * FSEL_PER_WORD + k;
                            if (p < FSEL_PINS && req.reg_index == 6'(w))
                            begin
                                fsel_next[p] = req.write_data[3*k +: 3];
                            end
                        end
                    end
                end
                W_SET0:    latch_next = latch_reg | lo_mask;
                W_SET1:    latch_next = latch_reg | hi_mask;
                W_CLR0:    latch_next = latch_reg & ~lo_mask;
                W_CLR1:    latch_next = latch_reg & ~hi_mask;
                W_PUD:     pud_next   = req.write_data[1:0];
                W_PUDCLK0, W_PUDCLK1:
                begin
                    for (int h = 0; h < 2; h++)
                    begin
                        for (int b = 0; b < 32; b++)
                        begin
                            p = h * 32 + b;
                            if (p < PIN_COUNT && req.write_data[b] &&
                                req.reg_index == (h == 0 ? W_PUDCLK0 : W_PUDCLK1))
                            begin
                                pull_next[p] = pud_reg;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FSEL_PINS; i++)
            begin
                fsel_reg[i] <= '0;
            end
            for (int i = 0; i < PIN_COUNT; i++)
            begin
                pull_reg[i] <= '0;
            end
            latch_reg <= '0;
            pud_reg   <= '0;
        end
        else if (en)
        begin
            fsel_reg  <= fsel_next;
            pull_reg  <= pull_next;
            latch_reg <= latch_next;
            pud_reg   <= pud_next;
        end
    end

    // read side: current state (reads never change it)
    logic [PINS_MAX-1:0][2:0] fsel_all;
    logic [63:0]              lev_all;
    logic [63:0]              latch_cur64;
    logic [63:0]              pad64;
    logic [31:0]              rd;

    assign latch_cur64 = 64'(latch_reg);
    assign pad64       = 64'(req.pad_levels);

    always_comb
    begin
        fsel_all = '0;
        for (int i = 0; i < FSEL_PINS; i++)
        begin
            fsel_all[i] = fsel_reg[i];
        end
        lev_all = '0;
        for (int i = 0; i < PIN_COUNT; i++)
        begin
            lev_all[i] = (fsel_all[i] == FSEL_OUTPUT && i < FSEL_PINS) ?
                         latch_cur64[i] : pad64[i];
        end
    end

    always_comb
    begin
        rd = '0;
        if (req.opcode == OP_READ)
        begin
            unique case (req.reg_index) inside
                [W_FSEL0:W_FSEL_LAST]:
                begin
                    for (int w = 0; w < FSEL_WORDS; w++)
                    begin
                        if (req.reg_index == 6'(w))
                        begin
                            rd = {2'b0, fsel_all[w*FSEL_PER_WORD +: FSEL_PER_WORD]};
                        end
                    end
                end
                W_LEV0:  rd = lev_all[31:0];
                W_LEV1:  rd = lev_all[63:32];
                W_PUD:   rd = {30'b0, pud_reg};
                default: rd = '0;
            endcase
        end
    end

    // pin-facing vectors from the updated state
    logic [63:0] latch_new64;
    logic [63:0] oe64;
    logic [63:0] pu64;
    logic [63:0] pd64;

    assign latch_new64 = 64'(latch_next);

    always_comb
    begin
        oe64 = '0;
        pu64 = '0;
        pd64 = '0;
        for (int i = 0; i < FSEL_PINS; i++)
        begin
            oe64[i] = (fsel_next[i] == FSEL_OUTPUT);
        end
        for (int i = 0; i < PIN_COUNT; i++)
        begin
            pu64[i] = (pull_next[i] == PULL_UP);
            pd64[i] = (pull_next[i] == PULL_DOWN);
        end
    end

    assign rsp.read_data         = rd;
    assign rsp.pin_drive         = latch_new64[PAD_COUNT-1:0];
    assign rsp.pin_output_enable = oe64[PAD_COUNT-1:0];
    assign rsp.pull_up_mask      = pu64[PAD_COUNT-1:0];
    assign rsp.pull_down_mask    = pd64[PAD_COUNT-1:0];

endmodule

>>> src/gpio_pin_register_block_top.sv
// Top level of the GPIO pin register block: request register, register file,
// response register. Depends on gpio_prb_pkg and gpio_prb_regfile.
//
// Usage:
//   Request channel  (req_valid / req_stall / req_data): one word access per
//   request - opcode (read/write), reg_index, write_data and the sampled pads.
//   Response channel (rsp_valid / rsp_stall / rsp_data): exactly one response
//   per request, in order: read_data plus the pin drive, output enable and
//   pull masks as they stand after the access.
//   Order: an accepted request lands in the request register; it is applied to
//   the registers when its response is loaded into the response register,
//   which drives rsp_valid and rsp_data.
//   Throughput: one request per cycle when rsp_stall is low, set by the single
//   register file update each request needs at the response-register load.
//   Stall: while the response register is held by rsp_stall, a request still
//   sits in the request register; only when both are full does req_stall rise.
//   Reset (rst_n low, asynchronous): both stages empty, all function selects
//   input, output latch clear, pull request and per-pin pull modes cleared.
//   Up to PIN_COUNT (1..64) pins are stored; pin vectors are 54 bits wide.
module gpio_pin_register_block_top
    import gpio_prb_pkg::*;
#(
    parameter int PIN_COUNT = 54
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  gpio_req_t req_data,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output gpio_rsp_t rsp_data
);

    logic      req_valid_reg;
    logic      req_valid_next;
    gpio_req_t req_reg;
    logic      rsp_valid_reg;
    logic      rsp_valid_next;
    gpio_rsp_t rsp_reg;
    gpio_rsp_t rsp_calc;
    logic      advance;
    logic      process;

    // response register can take a new entry when empty or being drained
    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign process   = req_valid_reg && advance;
    assign req_stall = req_valid_reg && !advance;

    gpio_prb_regfile #(
        .PIN_COUNT (PIN_COUNT)
    ) u_regfile (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (process),
        .req   (req_reg),
        .rsp   (rsp_calc)
    );

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (!req_stall)
        begin
            req_valid_next = req_valid;
        end
        rsp_valid_next = rsp_valid_reg;
        if (advance)
        begin
            rsp_valid_next = req_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            req_reg <= req_data;
        end
        if (process)
        begin
            rsp_reg <= rsp_calc;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // back-pressure only when both stages hold work
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall))
        else $error("request stalled while response stage could drain");

    // an accepted request is held in the request register next cycle
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_valid_reg)
        else $error("accepted request lost");

    // a processed request always produces a response
    a_process_responds: assert property (@(posedge clk) disable iff (!rst_n)
        process |=> rsp_valid)
        else $error("processed request gave no response");

    // a drained response with nothing behind it leaves the output empty
    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_stall && !req_valid_reg) |=> !rsp_valid)
        else $error("response repeated");

endmodule

>>> sim/gpio_pin_register_block_checker.sv
// Response checker for the GPIO pin register block: keeps its own copy of the
// register state, predicts one response per accepted request and compares it.
// Depends on gpio_prb_pkg.
`timescale 1ns / 100ps

module gpio_pin_register_block_checker
    import gpio_prb_pkg::*;
#(
    parameter int PIN_COUNT = 54
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_stall,
    input  gpio_req_t req_data,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  gpio_rsp_t rsp_data,
    output int        mismatch_count,
    output int        rsp_seen,
    output int        rsp_owed
);

    localparam logic [PINS_MAX-1:0] PIN_MASK = {PINS_MAX{1'b1}} >> (PINS_MAX - PIN_COUNT);

    logic [2:0]          fsel      [PINS_MAX];
    logic [1:0]          pull_mode [PINS_MAX];
    logic [PINS_MAX-1:0] latch;
    logic [1:0]          pull_req;
    gpio_rsp_t           owed_rsp[$];
    gpio_rsp_t           want;

    // Applies one access to the shadow state; returns the response it causes.
    function automatic gpio_rsp_t apply_access(gpio_req_t r);
        gpio_rsp_t           rsp;
        logic [PINS_MAX-1:0] lane;
        int                  pin;
        int                  k;
        rsp  = '0;
        lane = {32'b0, r.write_data};
        if (r.opcode == OP_WRITE)
        begin
            if (r.reg_index <= W_FSEL_LAST)
            begin
                for (k = 0; k < FSEL_PER_WORD; k++)
                begin
                    pin = r.reg_index * FSEL_PER_WORD + k;
                    if (pin < PIN_COUNT)
                        fsel[pin] = r.write_data[3*k +: 3];
                end
            end
            else if (r.reg_index == W_SET0 || r.reg_index == W_SET1)
                latch |= ((r.reg_index == W_SET1) ? lane << 32 : lane) & PIN_MASK;
            else if (r.reg_index == W_CLR0 || r.reg_index == W_CLR1)
                latch &= ~(((r.reg_index == W_CLR1) ? lane << 32 : lane) & PIN_MASK);
            else if (r.reg_index == W_PUD)
                pull_req = r.write_data[1:0];
            else if (r.reg_index == W_PUDCLK0 || r.reg_index == W_PUDCLK1)
            begin
                for (k = 0; k < 32; k++)
                begin
                    pin = ((r.reg_index == W_PUDCLK1) ? 32 : 0) + k;
                    if (pin < PIN_COUNT && r.write_data[k])
                        pull_mode[pin] = pull_req;
                end
            end
        end
        else
        begin
            if (r.reg_index <= W_FSEL_LAST)
            begin
                for (k = 0; k < FSEL_PER_WORD; k++)
                begin
                    pin = r.reg_index * FSEL_PER_WORD + k;
                    if (pin < PIN_COUNT)
                        rsp.read_data[3*k +: 3] = fsel[pin];
                end
            end
            else if (r.reg_index == W_LEV0 || r.reg_index == W_LEV1)
            begin
                for (k = 0; k < 32; k++)
                begin
                    pin = ((r.reg_index == W_LEV1) ? 32 : 0) + k;
                    if (pin < PIN_COUNT)
                    begin
                        if (fsel[pin] == FSEL_OUTPUT)
                            rsp.read_data[k] = latch[pin];
                        else if (pin < PAD_COUNT)
                            rsp.read_data[k] = r.pad_levels[pin];
                    end
                end
            end
            else if (r.reg_index == W_PUD)
                rsp.read_data = {30'b0, pull_req};
        end
        for (k = 0; k < PAD_COUNT; k++)
        begin
            if (k < PIN_COUNT)
            begin
                rsp.pin_output_enable[k] = (fsel[k] == FSEL_OUTPUT);
                rsp.pull_up_mask[k]      = (pull_mode[k] == PULL_UP);
                rsp.pull_down_mask[k]    = (pull_mode[k] == PULL_DOWN);
            end
        end
        rsp.pin_drive = latch[PAD_COUNT-1:0];
        return rsp;
    endfunction

    function automatic void check_field(string field, logic [63:0] exp_val,
                                        logic [63:0] act_val);
        if (act_val !== exp_val)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s mismatch: expected %h, got %h",
                         $realtime, field, exp_val, act_val);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (fsel[i])
            begin
                fsel[i]      = '0;
                pull_mode[i] = '0;
            end
            latch          = '0;
            pull_req       = '0;
            owed_rsp.delete();
            mismatch_count = 0;
            rsp_seen       = 0;
        end
        else
        begin
            // response first: a request taken at this edge cannot answer yet
            if (rsp_valid && !rsp_stall)
            begin
                rsp_seen++;
                if (owed_rsp.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: response with none expected: %h",
                                 $realtime, rsp_data);
                end
                else
                begin
                    want = owed_rsp.pop_front();
                    check_field("read_data", 64'(want.read_data),
                                64'(rsp_data.read_data));
                    check_field("pin_drive", 64'(want.pin_drive),
                                64'(rsp_data.pin_drive));
                    check_field("pin_output_enable", 64'(want.pin_output_enable),
                                64'(rsp_data.pin_output_enable));
                    check_field("pull_up_mask", 64'(want.pull_up_mask),
                                64'(rsp_data.pull_up_mask));
                    check_field("pull_down_mask", 64'(want.pull_down_mask),
                                64'(rsp_data.pull_down_mask));
                end
            end
            if (req_valid && !req_stall)
                owed_rsp.push_back(apply_access(req_data));
        end
        rsp_owed = owed_rsp.size();
    end

endmodule

>>> sim/tb_gpio_pin_register_block_top.sv
// Testbench top for the GPIO pin register block: clock, reset, request
// stimulus and response stalls; checking lives in the checker module.
// Depends on gpio_prb_pkg, gpio_pin_register_block_top and its checker.
`timescale 1ns / 100ps

module tb_gpio_pin_register_block_top;
    import gpio_prb_pkg::*;

    localparam int TOTAL_ITEMS = 1850;
    // Slowest legal item waits out the longest drawn idle gap and response stall
    // plus the pipeline, so this limit is far beyond any correct run.
    localparam int CYCLE_LIMIT = 400000;

    // Unmapped words used in the directed part.
    localparam logic [5:0] W_HOLE      = 6'd6;
    localparam logic [5:0] W_TOP_WORD  = 6'd63;

    // Function-select word with every field set to output.
    localparam logic [31:0] ALL_OUTPUT = 32'h0924_9249;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    gpio_req_t req_data  = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    gpio_rsp_t rsp_data;

    int mismatch_count;
    int rsp_seen;
    int rsp_owed;
    int issued      = 0;
    int cycle_count = 0;
    int rsp_hold    = 0;
    bit no_idle     = 1'b0;  // set for stretches of back-to-back traffic

    gpio_pin_register_block_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    gpio_pin_register_block_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_data       (req_data),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp_data       (rsp_data),
        .mismatch_count (mismatch_count),
        .rsp_seen       (rsp_seen),
        .rsp_owed       (rsp_owed)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop in case the block hangs or drops responses.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL gpio_pin_register_block_top");
            $finish;
        end
    end

    // Idle count for one request or response: random, or none in a busy stretch.
    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 12);
    endfunction

    // Pad samples: mostly random, sometimes all low or all high.
    function automatic logic [PAD_COUNT-1:0] random_pads();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PAD_COUNT'({$urandom, $urandom});
        endcase
    endfunction

    // Receiver side: after each taken response, hold stall high for a drawn
    // number of cycles. Stall never looks at anything but the handshake.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rsp_hold  <= 0;
        end
        else if (rsp_hold > 0)
        begin
            rsp_stall <= 1'b1;
            rsp_hold  <= rsp_hold - 1;
        end
        else
        begin
            rsp_stall <= 1'b0;
            if (rsp_valid && !rsp_stall)
                rsp_hold <= draw_wait();
        end
    end

    // Sends one request. Valid stays high after acceptance so a zero gap gives
    // back-to-back requests; a nonzero gap drops it first.
    task automatic issue(input logic op, input logic [5:0] word,
                         input logic [31:0] data, input logic [PAD_COUNT-1:0] pads);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= '{opcode: op, reg_index: word, write_data: data, pad_levels: pads};
        @(posedge clk);
        while (req_stall) @(posedge clk);
        issued++;
    endtask

    // Sender holds off until every outstanding response has come back.
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        wait (rsp_seen == issued);
    endtask

    initial
    begin
        logic [5:0]  word;
        logic [31:0] data;
        int          k;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // ---- directed part ----
        // reset value, then all-ones function selects incl. the unused top bits
        issue(OP_READ,  W_FSEL0,     '0,          random_pads());
        issue(OP_WRITE, W_FSEL0,     '1,          random_pads());
        issue(OP_READ,  W_FSEL0,     '0,          random_pads());
        // last word: only pins 50..53 exist
        issue(OP_WRITE, W_FSEL_LAST, '1,          random_pads());
        issue(OP_READ,  W_FSEL_LAST, '0,          random_pads());
        issue(OP_WRITE, W_FSEL0,     ALL_OUTPUT,  random_pads());
        issue(OP_WRITE, W_FSEL_LAST, ALL_OUTPUT,  random_pads());
        // latch set: bits of missing pins in the upper half are dropped
        issue(OP_WRITE, W_SET0,      '1,          random_pads());
        issue(OP_WRITE, W_SET1,      '1,          random_pads());
        // level reads mix latch (output pins) and pads (input pins)
        issue(OP_READ,  W_LEV0,      '0,          '0);
        issue(OP_READ,  W_LEV1,      '0,          '1);
        issue(OP_WRITE, W_CLR0,      32'hAAAA_AAAA, random_pads());
        issue(OP_WRITE, W_CLR1,      '1,          random_pads());
        issue(OP_READ,  W_LEV1,      '0,          '0);
        // write-only words read as zero, level words ignore writes
        issue(OP_READ,  W_SET0,      '1,          random_pads());
        issue(OP_READ,  W_PUDCLK1,   '1,          random_pads());
        issue(OP_WRITE, W_LEV0,      '1,          random_pads());
        // pull control keeps two bits; the reserved mode latches but sets no mask
        issue(OP_WRITE, W_PUD,       '1,          random_pads());
        issue(OP_READ,  W_PUD,       '0,          random_pads());
        issue(OP_WRITE, W_PUDCLK0,   '1,          random_pads());
        issue(OP_WRITE, W_PUD,       {30'b0, PULL_UP},   random_pads());
        issue(OP_WRITE, W_PUDCLK1,   '1,          random_pads());
        issue(OP_WRITE, W_PUD,       {30'b0, PULL_DOWN}, random_pads());
        issue(OP_WRITE, W_PUDCLK0,   32'h0000_FFFF, random_pads());
        issue(OP_WRITE, W_PUD,       32'h0000_0004, random_pads());
        // unmapped words
        issue(OP_WRITE, W_TOP_WORD,  '1,          random_pads());
        issue(OP_READ,  W_TOP_WORD,  '0,          random_pads());
        issue(OP_READ,  W_HOLE,      '0,          random_pads());
        drain();

        // ---- random part ----
        while (issued < TOTAL_ITEMS)
        begin
            if ($urandom_range(0, 99) == 0)
                no_idle = !no_idle;
            if ($urandom_range(0, 149) == 0)
                drain();

            if ($urandom_range(0, 6) == 0)
            begin
                // pull request, clock it into some pins, read it back
                issue(OP_WRITE, W_PUD, $urandom, random_pads());
                issue(OP_WRITE, W_PUDCLK0 + 6'($urandom_range(0, 1)),
                      $urandom & $urandom, random_pads());
                issue(OP_READ, W_PUD, $urandom, random_pads());
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: word = W_FSEL0 + 6'($urandom_range(0, 5));
                    3:       word = W_SET0 + 6'($urandom_range(0, 1));
                    4:       word = W_CLR0 + 6'($urandom_range(0, 1));
                    5, 6:    word = W_LEV0 + 6'($urandom_range(0, 1));
                    7:       word = W_PUDCLK0 + 6'($urandom_range(0, 1));
                    8:       word = W_PUD;
                    default: word = 6'($urandom_range(0, 63));
                endcase
                data = $urandom;
                if (word <= W_FSEL_LAST)
                begin
                    // lean toward output so level reads see the latch often
                    for (k = 0; k < FSEL_PER_WORD; k++)
                        if ($urandom_range(0, 1) == 0)
                            data[3*k +: 3] = FSEL_OUTPUT;
                end
                else if ($urandom_range(0, 3) == 0)
                    data = data & $urandom & $urandom;
                issue(1'($urandom_range(0, 1)), word, data, random_pads());
            end
        end
        req_valid <= 1'b0;

        // wait for the last responses, then a few cycles for strays
        wait (rsp_seen == issued);
        repeat (6) @(posedge clk);
        if (mismatch_count == 0 && rsp_owed == 0)
            $display("PASS gpio_pin_register_block_top");
        else
            $display("FAIL gpio_pin_register_block_top");
        $finish;
    end

endmodule

>>> files.f
src/gpio_prb_pkg.sv
src/gpio_prb_regfile.sv
src/gpio_pin_register_block_top.sv
sim/gpio_pin_register_block_checker.sv
sim/tb_gpio_pin_register_block_top.sv
